// ===== hdl/srte_pkg.sv =====
// Shared types, constants and helper functions of the sorted record table engine.
package srte_pkg;

  localparam int unsigned TableDepthDef = 128;
  localparam int unsigned NameCharsDef  = 8;
  localparam int unsigned NameW         = 64;
  localparam int unsigned KeyW          = 16;
  localparam int unsigned ScoreW        = 15;
  localparam int unsigned RecW          = NameW + KeyW + ScoreW;
  localparam logic [ScoreW-1:0] ScoreMax = 15'd25600;

  // Command codes from the controller to the datapath.
  localparam logic [3:0] C_NONE = 4'd0, C_LATCH = 4'd1, C_RD = 4'd2, C_WRPREV = 4'd3,
                         C_WRNEW = 4'd4, C_WRHOLD = 4'd5, C_CMP = 4'd6, C_ACC = 4'd7,
                         C_MATH = 4'd8, C_CLR = 4'd9;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SORT   = 3'd2,
    OP_FIND   = 3'd3,
    OP_STATS  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Keeps the first nchars bytes and clears everything from the first NUL on.
  function automatic logic [NameW-1:0] canon_name(input logic [NameW-1:0] v,
                                                  input int unsigned nchars);
    logic [NameW-1:0] o;
    logic             stop;
    o    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= nchars || v[NameW-1-8*i -: 8] == 8'd0) stop = 1'b1;
      if (!stop) o[NameW-1-8*i -: 8] = v[NameW-1-8*i -: 8];
    end
    return o;
  endfunction

  function automatic logic [NameW-1:0] top_mask(input logic [3:0] n);
    logic [NameW-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[NameW-1-8*i -: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ===== hdl/srte_ram.sv =====
// Generic single-port RAM with registered read data.
module srte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/srte_ctrl.sv =====
// Controller state machine: sequences every operation over the record RAM.
module srte_ctrl #(
  parameter int unsigned TABLE_DEPTH = srte_pkg::TableDepthDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_op,
  input  logic                           out_taken,
  input  logic                           dp_hit,
  input  logic                           dp_swap,
  input  logic                           dp_math_done,
  output logic                           out_valid,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] cnt,
  output logic [$clog2(TABLE_DEPTH)-1:0]   addr,
  output logic [3:0]                     cmd,
  output logic [1:0]                     status
);
  import srte_pkg::*;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SCAN  = 11'b00000000010,
    S_SCANW = 11'b00000000100,
    S_SHRD  = 11'b00000001000,
    S_SHWR  = 11'b00000010000,
    S_PUT   = 11'b00000100000,
    S_SRTA  = 11'b00001000000,
    S_SRTB  = 11'b00010000000,
    S_SRTW  = 11'b00100000000,
    S_MATH  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t        st_r, st_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, lim_r, lim_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          sw_r, sw_nxt;

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  assign cnt       = cnt_r;
  assign status    = stat_r;

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; cnt_nxt = cnt_r; i_nxt = i_r; lim_nxt = lim_r;
    stat_nxt = stat_r; sw_nxt = sw_r;
    cmd = C_NONE; addr = i_r[AW-1:0];
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = C_LATCH; op_nxt = in_op; i_nxt = '0; stat_nxt = ST_OK;
          case (in_op)
            OP_INSERT: begin
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                stat_nxt = ST_FULL; st_nxt = S_DONE;
              end else if (cnt_r == '0) st_nxt = S_PUT;
              else st_nxt = S_SCAN;
            end
            OP_DELETE, OP_FIND: begin
              stat_nxt = ST_NOT_FOUND;
              st_nxt = (cnt_r == '0) ? S_DONE : S_SCAN;
            end
            OP_SORT: begin
              lim_nxt = cnt_r - CW'(1);
              st_nxt = (cnt_r < CW'(2)) ? S_DONE : S_SRTA;
              sw_nxt = 1'b0;
            end
            OP_STATS: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_EMPTY; st_nxt = S_DONE;
              end else st_nxt = S_SCAN;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd = C_RD; st_nxt = S_SCANW;
      end
      S_SCANW: begin
        // Read data of entry i is visible now.
        case (op_r)
          OP_INSERT: begin
            if (dp_hit) begin
              // Shift entries i..cnt-1 up, starting from the top.
              i_nxt = cnt_r; lim_nxt = i_r; st_nxt = S_SHRD;
            end else if (i_r + CW'(1) == cnt_r) begin
              i_nxt = cnt_r; st_nxt = S_PUT;
            end else begin
              i_nxt = i_r + CW'(1); st_nxt = S_SCAN;
            end
          end
          OP_DELETE: begin
            if (dp_hit) begin
              stat_nxt = ST_OK; cnt_nxt = cnt_r - CW'(1);
              st_nxt = (i_r + CW'(1) == cnt_r) ? S_DONE : S_SHRD;
              i_nxt = i_r + CW'(1);
            end else if (i_r + CW'(1) == cnt_r) st_nxt = S_DONE;
            else begin
              i_nxt = i_r + CW'(1); st_nxt = S_SCAN;
            end
          end
          OP_FIND: begin
            cmd = C_CMP;
            if (dp_hit) begin
              stat_nxt = ST_OK; st_nxt = S_DONE;
            end else if (i_r + CW'(1) == cnt_r) st_nxt = S_DONE;
            else begin
              i_nxt = i_r + CW'(1); st_nxt = S_SCAN;
            end
          end
          default: begin
            cmd = C_ACC;
            if (i_r + CW'(1) == cnt_r) st_nxt = S_MATH;
            else begin
              i_nxt = i_r + CW'(1); st_nxt = S_SCAN;
            end
          end
        endcase
      end
      S_SHRD: begin
        // Insert reads i-1 to write at i; delete reads i to write at i-1.
        addr = (op_r == OP_INSERT) ? AW'(i_r - CW'(1)) : i_r[AW-1:0];
        cmd = C_RD; st_nxt = S_SHWR;
      end
      S_SHWR: begin
        cmd = C_WRPREV;
        if (op_r == OP_INSERT) begin
          addr = i_r[AW-1:0];
          i_nxt = i_r - CW'(1);
          st_nxt = (i_r - CW'(1) == lim_r) ? S_PUT : S_SHRD;
        end else begin
          addr = AW'(i_r - CW'(1));
          i_nxt = i_r + CW'(1);
          st_nxt = (i_r == cnt_r) ? S_DONE : S_SHRD;
        end
      end
      S_PUT: begin
        cmd = C_WRNEW; cnt_nxt = cnt_r + CW'(1); st_nxt = S_DONE;
      end
      S_SRTA: begin
        cmd = C_RD; st_nxt = S_SRTB; // entry i
      end
      S_SRTB: begin
        cmd = C_CLR; addr = AW'(i_r + CW'(1)); st_nxt = S_SRTW; // hold a, read b
      end
      S_SRTW: begin
        // The second write of a swap does not look at the compare again, since
        // the read port has moved on to the old word at i by then.
        if (sw_r) begin
          cmd = C_WRHOLD; addr = AW'(i_r + CW'(1)); sw_nxt = 1'b0; // a to i+1
        end else if (dp_swap) begin
          cmd = C_WRPREV; addr = i_r[AW-1:0]; sw_nxt = 1'b1; // b to i
        end
        if (!dp_swap || sw_r) begin
          if (i_r + CW'(1) >= lim_r) begin
            i_nxt = '0; lim_nxt = lim_r - CW'(1);
            st_nxt = (lim_r == CW'(1)) ? S_DONE : S_SRTA;
          end else begin
            i_nxt = i_r + CW'(1); st_nxt = S_SRTA;
          end
        end
      end
      S_MATH: begin
        cmd = C_MATH;
        if (dp_math_done) st_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_taken) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; i_r <= '0; lim_r <= '0; op_r <= '0;
      stat_r <= '0; sw_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; i_r <= i_nxt; lim_r <= lim_nxt; op_r <= op_nxt;
      stat_r <= stat_nxt; sw_r <= sw_nxt;
    end
  end
endmodule

// ===== hdl/srte_dp.sv =====
// Datapath: record RAM, operand latches, statistics accumulators and math unit.
module srte_dp #(
  parameter int unsigned TABLE_DEPTH = srte_pkg::TableDepthDef,
  parameter int unsigned NAME_CHARS  = srte_pkg::NameCharsDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [3:0]                        cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0]    addr,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]  cnt,
  input  logic [2:0]                        in_op,
  input  logic [srte_pkg::KeyW-1:0]         in_roll,
  input  logic [srte_pkg::ScoreW-1:0]       in_score,
  input  logic [srte_pkg::NameW-1:0]        in_name_key,
  input  logic [3:0]                        in_prefix_len,
  output logic                              hit,
  output logic                              swap,
  output logic                              math_done,
  output logic [srte_pkg::NameW-1:0]        name_out,
  output logic [6:0]                        highest,
  output logic [6:0]                        lowest,
  output logic [6:0]                        mean_score,
  output logic [6:0]                        std_dev
);
  import srte_pkg::*;
  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned S1W = ScoreW + CW;
  localparam int unsigned S2W = 2 * ScoreW + CW;
  localparam int unsigned XW  = S2W + CW;
  localparam int unsigned QW  = XW / 2 + 1;

  logic [RecW-1:0]   rd, wdata, hold_r;
  logic              we;
  logic [2:0]        op_r;
  logic [KeyW-1:0]   key_r;
  logic [ScoreW-1:0] sc_r;
  logic [NameW-1:0]  nm_r, mask_r, nout_r;
  logic [S1W-1:0]    s1_r;
  logic [S2W-1:0]    s2_r;
  logic [ScoreW-1:0] mx_r, mn_r;
  logic              first_r;
  logic [2*ScoreW-1:0] sq;
  logic [NameW-1:0]  rd_name;
  logic [KeyW-1:0]   rd_key;
  logic [ScoreW-1:0] rd_sc;

  assign rd_name = rd[RecW-1 -: NameW];
  assign rd_key  = rd[ScoreW +: KeyW];
  assign rd_sc   = rd[ScoreW-1:0];

  always_comb begin
    we = 1'b0; wdata = rd;
    case (cmd)
      C_WRPREV: we = 1'b1;
      C_WRNEW: begin
        we = 1'b1; wdata = {nm_r, key_r, sc_r};
      end
      C_WRHOLD: begin
        we = 1'b1; wdata = hold_r;
      end
      default: we = 1'b0;
    endcase
  end

  srte_ram #(.WIDTH(RecW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rd)
  );

  always_comb begin
    case (op_r)
      OP_INSERT: hit = rd_key > key_r;
      OP_DELETE: hit = rd_key == key_r;
      OP_FIND:   hit = ((rd_name ^ nm_r) & mask_r) == '0;
      default:   hit = 1'b0;
    endcase
  end
  assign swap = hold_r[RecW-1 -: NameW] > rd_name;
  assign sq = rd_sc * rd_sc;

  // Math unit: a sequential multiply, restoring divides and a bit-pair integer square root.
  typedef enum logic [4:0] {
    M_IDLE = 5'b00001, M_MUL = 5'b00010, M_SQRT = 5'b00100, M_DIV = 5'b01000,
    M_FIN = 5'b10000
  } mstate_t;
  mstate_t          ms_r;
  logic [XW-1:0]    x_r, r_r;
  logic [XW-1:0]    bit_r;
  logic [CW-1:0]    mc_r;
  logic [S1W+CW:0]  den;
  logic [XW-1:0]    drem_r, dquo_r;
  logic [6:0]       dcnt_r;
  logic             dphase_r;
  logic [XW-1:0]    numsel;
  logic             mphase_r;
  logic [XW-1:0]    sqa_r;
  logic [S1W-1:0]   sqb_r;

  assign den = (S1W+CW+1)'({cnt, 8'd0});
  assign math_done = (ms_r == M_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= M_IDLE; mean_score <= '0; std_dev <= '0;
    end else begin
      case (ms_r)
        M_IDLE: begin
          if (cmd == C_LATCH) begin
            mean_score <= '0; std_dev <= '0;
          end else if (cmd == C_MATH) begin
            ms_r <= M_MUL; x_r <= '0; mc_r <= '0; mphase_r <= 1'b0;
            sqa_r <= XW'(s1_r); sqb_r <= s1_r;
          end
        end
        M_MUL: begin
          // n*s2 by repeated add, then s1*s1 subtracted one shifted partial
          // product per cycle.
          if (!mphase_r) begin
            if (mc_r != cnt) begin
              x_r <= x_r + XW'(s2_r); mc_r <= mc_r + CW'(1);
            end else mphase_r <= 1'b1;
          end else if (sqb_r != '0) begin
            if (sqb_r[0]) x_r <= x_r - sqa_r;
            sqa_r <= sqa_r << 1;
            sqb_r <= sqb_r >> 1;
          end else begin
            r_r <= '0; bit_r <= XW'(1) << (2 * (XW / 2) - 2);
            ms_r <= M_SQRT;
          end
        end
        M_SQRT: begin
          if (bit_r == '0) begin
            ms_r <= M_DIV; dphase_r <= 1'b0; drem_r <= '0; dquo_r <= XW'(s1_r);
            dcnt_r <= 7'(XW);
          end else begin
            if (x_r >= r_r + bit_r) begin
              x_r <= x_r - (r_r + bit_r); r_r <= (r_r >> 1) + bit_r;
            end else r_r <= r_r >> 1;
            bit_r <= bit_r >> 2;
          end
        end
        M_DIV: begin
          if (dcnt_r == '0) begin
            if (!dphase_r) begin
              mean_score <= dquo_r[6:0]; dphase_r <= 1'b1;
              drem_r <= '0; dquo_r <= r_r; dcnt_r <= 7'(XW);
            end else begin
              std_dev <= dquo_r[6:0]; ms_r <= M_FIN;
            end
          end else begin
            if ({drem_r[XW-2:0], dquo_r[XW-1]} >= XW'(den)) begin
              drem_r <= {drem_r[XW-2:0], dquo_r[XW-1]} - XW'(den);
              dquo_r <= {dquo_r[XW-2:0], 1'b1};
            end else begin
              drem_r <= {drem_r[XW-2:0], dquo_r[XW-1]};
              dquo_r <= {dquo_r[XW-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 7'd1;
          end
        end
        M_FIN: ms_r <= M_IDLE;
        default: ms_r <= M_IDLE;
      endcase
    end
  end
  assign numsel = '0;

  always_ff @(posedge clk) begin
    case (cmd)
      C_LATCH: begin
        op_r   <= in_op;
        key_r  <= in_roll;
        sc_r   <= (in_score > ScoreMax) ? ScoreMax : in_score;
        nm_r   <= canon_name(in_name_key, NAME_CHARS);
        mask_r <= top_mask((in_prefix_len > 4'(NAME_CHARS)) ? 4'(NAME_CHARS)
                                                             : in_prefix_len);
        nout_r <= '0; s1_r <= '0; s2_r <= '0; first_r <= 1'b1;
        highest <= '0; lowest <= '0;
      end
      C_CMP: if (hit) nout_r <= rd_name;
      C_CLR: hold_r <= rd;
      C_ACC: begin
        s1_r <= s1_r + S1W'(rd_sc);
        s2_r <= s2_r + S2W'(sq);
        if (first_r || rd_sc > mx_r) mx_r <= rd_sc;
        if (first_r || rd_sc < mn_r) mn_r <= rd_sc;
        first_r <= 1'b0;
      end
      C_MATH: begin
        highest <= mx_r[ScoreW-1:8];
        lowest  <= mn_r[ScoreW-1:8];
      end
      default: ;
    endcase
  end
  assign name_out = nout_r ^ numsel[NameW-1:0];
endmodule

// ===== hdl/sorted_record_table_engine.sv =====
// Top level of the sorted record table engine: controller plus datapath.
// Sort reads, holds and compares each neighbouring pair and writes both words
// back on a swap; stats scans the table, then runs the multiply, the squared
// sum, the square root and the divides.
// One item is in flight at a time; the single-port record RAM sets the pace.
// Reset (rst_n low, synchronous) empties the table; RAM contents are not cleared.
module sorted_record_table_engine #(
  parameter int unsigned TABLE_DEPTH = srte_pkg::TableDepthDef,
  parameter int unsigned NAME_CHARS  = srte_pkg::NameCharsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_op,
  input  logic [srte_pkg::KeyW-1:0]    in_roll,
  input  logic [srte_pkg::ScoreW-1:0]  in_score,
  input  logic [srte_pkg::NameW-1:0]   in_name_key,
  input  logic [3:0]                   in_prefix_len,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [srte_pkg::NameW-1:0]   out_name_out,
  output logic [7:0]                   out_count,
  output logic [6:0]                   out_highest,
  output logic [6:0]                   out_lowest,
  output logic [6:0]                   out_mean_score,
  output logic [6:0]                   out_std_dev
);
  import srte_pkg::*;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic          hit, swap, math_done;
  logic [CW-1:0] cnt;
  logic [AW-1:0] addr;
  logic [3:0]    cmd;

  // The controller owns the entry count and walks the RAM address; the
  // datapath answers with compare results for each word it reads.
  srte_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .out_taken(!out_stall), .dp_hit(hit), .dp_swap(swap), .dp_math_done(math_done),
    .out_valid(out_valid), .cnt(cnt), .addr(addr), .cmd(cmd), .status(out_status)
  );

  srte_dp #(.TABLE_DEPTH(TABLE_DEPTH), .NAME_CHARS(NAME_CHARS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .addr(addr), .cnt(cnt), .in_op(in_op),
    .in_roll(in_roll), .in_score(in_score), .in_name_key(in_name_key),
    .in_prefix_len(in_prefix_len), .hit(hit), .swap(swap), .math_done(math_done),
    .name_out(out_name_out), .highest(out_highest), .lowest(out_lowest),
    .mean_score(out_mean_score), .std_dev(out_std_dev)
  );

  // The count output is the low eight bits of the entry count.
  assign out_count = 8'(cnt);
endmodule

// ===== hdl/srte_checker.sv =====
// Port-level checker for the sorted record table engine, bound to the top level.
module srte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [7:0] out_count
);
  import srte_pkg::*;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted while a result is pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_count == 8'd0)
    else $error("empty status with nonzero count");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind sorted_record_table_engine srte_checker u_srte_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_count(out_count)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the sorted record table engine.
`timescale 1ns / 1ps

module testbench;
  import srte_pkg::*;

  localparam int unsigned Depth = 128;
  localparam int unsigned Chars = 8;
  localparam int unsigned LimitCycles = 3000000;

  // One input word as the driver presents it.
  typedef struct {
    logic [2:0]        op;
    logic [KeyW-1:0]   roll;
    logic [ScoreW-1:0] score;
    logic [NameW-1:0]  name;
    logic [3:0]        plen;
  } cmd_t;

  // One result word as the monitor expects it.
  typedef struct {
    logic [1:0]       status;
    logic [NameW-1:0] name_out;
    logic [7:0]       count;
    logic [6:0]       highest;
    logic [6:0]       lowest;
    logic [6:0]       mean;
    logic [6:0]       sd;
  } reply_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_op;
  logic [KeyW-1:0] in_roll;
  logic [ScoreW-1:0] in_score;
  logic [NameW-1:0] in_name_key;
  logic [3:0] in_prefix_len;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic [NameW-1:0] out_name_out;
  logic [7:0] out_count;
  logic [6:0] out_highest, out_lowest, out_mean_score, out_std_dev;

  sorted_record_table_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_roll(in_roll), .in_score(in_score),
    .in_name_key(in_name_key), .in_prefix_len(in_prefix_len),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_name_out(out_name_out), .out_count(out_count),
    .out_highest(out_highest), .out_lowest(out_lowest),
    .out_mean_score(out_mean_score), .out_std_dev(out_std_dev)
  );

  // Shadow copy of the record table, kept by the predictor.
  logic [NameW-1:0]  tbl_name [Depth];
  logic [KeyW-1:0]   tbl_key  [Depth];
  logic [ScoreW-1:0] tbl_score[Depth];
  int unsigned       tbl_count;

  cmd_t   pending_cmds[$];
  reply_t awaited_replies[$];
  int     mismatches;
  int     cycle_count;
  bit     stim_done;
  bit     hold_sender;
  bit     in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Trims a name to the first NUL and the configured character count.
  function automatic logic [NameW-1:0] trim_name(logic [NameW-1:0] v);
    logic [NameW-1:0] o;
    bit stop;
    o = '0;
    stop = 0;
    for (int i = 0; i < 8; i++) begin
      if (i >= Chars || v[NameW-1-8*i -: 8] == 8'd0) stop = 1;
      if (!stop) o[NameW-1-8*i -: 8] = v[NameW-1-8*i -: 8];
    end
    return o;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Applies one command to the shadow table and returns the result word.
  function automatic reply_t apply_table_cmd(cmd_t c);
    reply_t r;
    logic [NameW-1:0] nm, msk, tn;
    logic [KeyW-1:0] tk;
    logic [ScoreW-1:0] sc, ts, mx, mn;
    int unsigned i, pl;
    longint unsigned n, s1, s2;
    r = '{default: '0};
    nm = trim_name(c.name);
    sc = c.score;
    case (c.op)
      OP_INSERT: begin
        if (tbl_count >= Depth) begin
          r.status = ST_FULL;
        end else begin
          if (sc > ScoreMax) sc = ScoreMax;
          i = 0;
          while (i < tbl_count && tbl_key[i] <= c.roll) i++;
          for (int j = tbl_count; j > i; j--) begin
            tbl_name[j] = tbl_name[j-1];
            tbl_key[j] = tbl_key[j-1];
            tbl_score[j] = tbl_score[j-1];
          end
          tbl_name[i] = nm;
          tbl_key[i] = c.roll;
          tbl_score[i] = sc;
          tbl_count++;
        end
      end
      OP_DELETE: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_key[i] == c.roll) begin
            for (int j = i; j + 1 < tbl_count; j++) begin
              tbl_name[j] = tbl_name[j+1];
              tbl_key[j] = tbl_key[j+1];
              tbl_score[j] = tbl_score[j+1];
            end
            tbl_count--;
            r.status = ST_OK;
            break;
          end
        end
      end
      OP_SORT: begin
        for (int a = 0; a + 1 < tbl_count; a++) begin
          for (int j = 0; j + 1 < tbl_count - a; j++) begin
            if (tbl_name[j] > tbl_name[j+1]) begin
              tn = tbl_name[j]; tk = tbl_key[j]; ts = tbl_score[j];
              tbl_name[j] = tbl_name[j+1];
              tbl_key[j] = tbl_key[j+1];
              tbl_score[j] = tbl_score[j+1];
              tbl_name[j+1] = tn; tbl_key[j+1] = tk; tbl_score[j+1] = ts;
            end
          end
        end
      end
      OP_FIND: begin
        pl = (c.plen > Chars) ? Chars : c.plen;
        msk = '0;
        for (int b = 0; b < 8; b++) if (b < pl) msk[NameW-1-8*b -: 8] = 8'hFF;
        r.status = ST_NOT_FOUND;
        for (i = 0; i < tbl_count; i++) begin
          if (((tbl_name[i] ^ nm) & msk) == '0) begin
            r.name_out = tbl_name[i];
            r.status = ST_OK;
            break;
          end
        end
      end
      OP_STATS: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          n = tbl_count;
          s1 = 0;
          s2 = 0;
          mx = tbl_score[0];
          mn = tbl_score[0];
          for (i = 0; i < tbl_count; i++) begin
            s1 += tbl_score[i];
            s2 += longint'(tbl_score[i]) * tbl_score[i];
            if (tbl_score[i] > mx) mx = tbl_score[i];
            if (tbl_score[i] < mn) mn = tbl_score[i];
          end
          r.highest = 7'(mx >> 8);
          r.lowest = 7'(mn >> 8);
          r.mean = 7'(s1 / (n * 256));
          r.sd = 7'(int_sqrt(n * s2 - s1 * s1) / (n * 256));
        end
      end
      default: ;
    endcase
    r.count = 8'(tbl_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // Builds random names; short ones and shared prefixes make find and sort interesting.
  function automatic logic [NameW-1:0] rand_name();
    logic [NameW-1:0] v;
    int k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 3);
    if (k == 0) v[NameW-1 -: 16] = 16'h4142;
    if (k == 1) v[NameW-1-8*$urandom_range(1, 7) -: 8] = 8'h00;
    return v;
  endfunction

  function automatic cmd_t rand_cmd(int fill_bias);
    cmd_t c;
    int p;
    p = $urandom_range(0, 99);
    if (p < fill_bias) c.op = OP_INSERT;
    else if (p < fill_bias + 15) c.op = OP_DELETE;
    else if (p < fill_bias + 20) c.op = OP_SORT;
    else if (p < fill_bias + 35) c.op = OP_FIND;
    else if (p < 98) c.op = OP_STATS;
    else c.op = 3'($urandom_range(5, 7));
    c.roll = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
    c.score = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 25600));
    c.name = rand_name();
    c.plen = 4'($urandom);
    return c;
  endfunction

  function automatic cmd_t mk(logic [2:0] op, logic [15:0] roll, logic [14:0] sc,
                              logic [63:0] nm, logic [3:0] pl);
    cmd_t c;
    c.op = op; c.roll = roll; c.score = sc; c.name = nm; c.plen = pl;
    return c;
  endfunction

  // Stimulus: directed corners, a pause until drained, then random traffic.
  initial begin
    mismatches = 0;
    stim_done = 0;
    hold_sender = 0;
    tbl_count = 0;
    pending_cmds.push_back(mk(OP_STATS, 0, 0, 0, 0));            // empty stats
    pending_cmds.push_back(mk(OP_FIND, 0, 0, 0, 0));             // empty find
    pending_cmds.push_back(mk(OP_DELETE, 5, 0, 0, 0));           // delete on empty
    pending_cmds.push_back(mk(OP_INSERT, 16'hFFFF, 15'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    pending_cmds.push_back(mk(OP_INSERT, 0, 0, 64'h0, 4'hF));
    pending_cmds.push_back(mk(OP_INSERT, 100, 25600, 64'h4142_0043_4445_4647, 0));
    pending_cmds.push_back(mk(OP_INSERT, 100, 12800, 64'h4142_4344_0000_0000, 0));
    pending_cmds.push_back(mk(OP_INSERT, 7, 25601, 64'h4100_0000_0000_0000, 0));
    pending_cmds.push_back(mk(OP_STATS, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_FIND, 0, 0, 64'h4142_0000_0000_0000, 0));  // zero length
    pending_cmds.push_back(mk(OP_FIND, 0, 0, 64'h4142_4300_0000_0000, 3));
    pending_cmds.push_back(mk(OP_FIND, 0, 0, 64'h4142_4344_0000_0000, 4'hF));
    pending_cmds.push_back(mk(OP_FIND, 0, 0, 64'h5A5A_0000_0000_0000, 2));  // no match
    pending_cmds.push_back(mk(OP_SORT, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_FIND, 0, 0, 0, 8));
    pending_cmds.push_back(mk(OP_DELETE, 100, 0, 0, 0));
    pending_cmds.push_back(mk(OP_DELETE, 1234, 0, 0, 0));
    pending_cmds.push_back(mk(3'd7, 16'hFFFF, 15'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF));
    pending_cmds.push_back(mk(3'd5, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_STATS, 0, 0, 0, 0));
    wait (pending_cmds.size() == 0);
    hold_sender = 1;
    wait (awaited_replies.size() == 0);
    hold_sender = 0;
    for (int i = 0; i < 80; i++) pending_cmds.push_back(rand_cmd(i < 40 ? 45 : 30));
    stim_done = 1;
  end

  // Acceptance is seen at the rising edge; the predictor runs right there.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      awaited_replies.push_back(apply_table_cmd(pending_cmds.pop_front()));
    end
  end

  // Driver: bursts of words with random gaps.
  int burst_left, gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          in_op <= pending_cmds[0].op;
          in_roll <= pending_cmds[0].roll;
          in_score <= pending_cmds[0].score;
          in_name_key <= pending_cmds[0].name;
          in_prefix_len <= pending_cmds[0].plen;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 8);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: long free stretches mixed with random stalls.
  int stall_phase;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 64;
      out_stall <= (stall_phase < 24) ? 1'b0 : ($urandom_range(0, 2) == 0);
    end
  end

  // Monitor: compares each accepted result word with the oldest prediction.
  reply_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected word", out_status, 0);
      end else begin
        want = awaited_replies.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_name_out !== want.name_out) report_mismatch("name_out", out_name_out, want.name_out);
        if (out_count !== want.count) report_mismatch("count", out_count, want.count);
        if (out_highest !== want.highest) report_mismatch("highest", out_highest, want.highest);
        if (out_lowest !== want.lowest) report_mismatch("lowest", out_lowest, want.lowest);
        if (out_mean_score !== want.mean) report_mismatch("mean", out_mean_score, want.mean);
        if (out_std_dev !== want.sd) report_mismatch("std_dev", out_std_dev, want.sd);
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Reset, then wait for the stimulus to drain and the last words to arrive.
  initial begin
    cycle_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    in_roll = '0;
    in_score = '0;
    in_name_key = '0;
    in_prefix_len = '0;
    out_stall = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (stim_done && pending_cmds.size() == 0 && !in_valid);
    wait (awaited_replies.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
